// ----- sv/tsat_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsat_pkg
// Shared constants and types of the 2-SAT depth-first solver.
// ----------------------------------------------------------------------------
package tsat_pkg;
   localparam int NUM_VARS  = 32;
   localparam int MAX_EDGES = 1024;
   localparam int NUM_LITS  = 2 * NUM_VARS;
   localparam int VAR_W     = $clog2(NUM_VARS);
   localparam int LIT_W     = VAR_W + 1;
   localparam int CNT_W     = $clog2(NUM_VARS + 1);
   localparam int EDGE_W    = $clog2(MAX_EDGES + 1);
   localparam int EIDX_W    = $clog2(MAX_EDGES);
   localparam int DEPTH_W   = $clog2(NUM_LITS + 1);
   localparam logic [EDGE_W-1:0] NIL_EDGE = EDGE_W'(MAX_EDGES);
   localparam logic [5:0] VAR_COUNT_RESET = 6'd32;

   typedef enum logic [1:0] {
      OP_ADD   = 2'd0,
      OP_SOLVE = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NONE  = 2'd3
   } op_type;
endpackage
`default_nettype wire

// ----- sv/tsat_ifs.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsat channel interfaces
// Valid/ready channels for solver requests and results.
// ----------------------------------------------------------------------------
interface tsat_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] op;
   logic [5:0] src_literal;
   logic [5:0] dst_literal;
   modport source (output valid, op, src_literal, dst_literal, input ready);
   modport sink   (input valid, op, src_literal, dst_literal, output ready);
endinterface

interface tsat_rsp_if;
   logic       valid;
   logic       ready;
   logic       satisfiable;
   logic [4:0] variable;
   logic       chosen_literal;
   logic       edges_dropped;
   logic       last;
   modport source (output valid, satisfiable, variable, chosen_literal, edges_dropped,
                   last, input ready);
   modport sink   (input valid, satisfiable, variable, chosen_literal, edges_dropped,
                   last, output ready);
endinterface
`default_nettype wire

// ----- sv/two_sat_dfs_solver.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Add: list head read, then edge write. Clear: done in the idle state. Solve:
// walks the stored edges through the edge memory and the walk stack, then
// emits one result per cycle while the result channel is not stalled.
// Synchronous active-high reset empties all lists, clears marks, overflow flag
// and output valid; var_count resets to 32. No clearing pass is needed.
// ----------------------------------------------------------------------------
// two_sat_dfs_solver
// 2-SAT solver over stored implication lists, depth-first with backtracking.
// ----------------------------------------------------------------------------
module two_sat_dfs_solver (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_wr_en,
   input  wire logic [5:0] csr_wr_data,
   tsat_req_if.sink        req_chan,
   tsat_rsp_if.source      rsp_chan
);
   import tsat_pkg::*;

   typedef enum logic [9:0] {
      ST_IDLE  = 10'b0000000001,
      ST_ADD   = 10'b0000000010,
      ST_VAR   = 10'b0000000100,
      ST_TRY   = 10'b0000001000,
      ST_HEAD  = 10'b0000010000,
      ST_WALK  = 10'b0000100000,
      ST_POP   = 10'b0001000000,
      ST_EDGE  = 10'b0010000000,
      ST_EMIT  = 10'b0100000000,
      ST_UNSAT = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;
   logic [5:0]          var_count_ff;
   logic [EDGE_W-1:0]   count_ff, count_in;
   logic                flag_ff, flag_in;
   logic [NUM_LITS-1:0] hvalid_ff, hvalid_in;
   logic [NUM_LITS-1:0] marked_ff, marked_in;
   logic [NUM_LITS-1:0] attempt_ff, attempt_in;
   logic [LIT_W-1:0]    src_ff, src_in, dst_ff, dst_in;
   logic [LIT_W-1:0]    lit_ff, lit_in, ent_ff, ent_in;
   logic                phase_ff, phase_in;
   logic [CNT_W-1:0]    v_ff, v_in, nv_ff, nv_in;
   logic [DEPTH_W-1:0]  depth_ff, depth_in;
   logic [EDGE_W-1:0]   top_ff, top_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_sat_ff, rsp_sat_in, rsp_cho_ff, rsp_cho_in;
   logic                rsp_drop_ff, rsp_drop_in, rsp_last_ff, rsp_last_in;
   logic [4:0]          rsp_var_ff, rsp_var_in;

   // memories
   logic [EDGE_W-1:0]        head_mem [NUM_LITS];
   logic [LIT_W+EDGE_W-1:0]  edge_mem [MAX_EDGES];
   logic [EDGE_W-1:0]        stk_mem  [NUM_LITS];
   logic [EDGE_W-1:0]        head_q, stk_q;
   logic [LIT_W+EDGE_W-1:0]  edge_q;
   logic                     head_we, edge_we, stk_we;
   logic [LIT_W-1:0]         head_ra, stk_wa, stk_ra;
   logic [EIDX_W-1:0]        edge_ra;

   logic                     slot_free;
   logic [LIT_W-1:0]         t_lit, t_comp, lit_comp;
   logic [EDGE_W-1:0]        t_link;
   logic [DEPTH_W-1:0]       depth_m1, depth_m2;
   logic [LIT_W-1:0]         v_lit;

   assign slot_free = !rsp_valid_ff || rsp_chan.ready;
   assign t_lit     = edge_q[LIT_W+EDGE_W-1:EDGE_W];
   assign t_link    = edge_q[EDGE_W-1:0];
   assign t_comp    = {t_lit[LIT_W-1:1], ~t_lit[0]};
   assign lit_comp  = {lit_ff[LIT_W-1:1], ~lit_ff[0]};
   assign depth_m1  = depth_ff - DEPTH_W'(1);
   assign depth_m2  = depth_ff - DEPTH_W'(2);
   assign v_lit     = {v_ff[VAR_W-1:0], 1'b0};
   assign stk_wa    = depth_m1[LIT_W-1:0];
   assign stk_ra    = depth_m2[LIT_W-1:0];
   assign edge_ra   = top_ff[EIDX_W-1:0];

   assign req_chan.ready          = (state_ff == ST_IDLE);
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.satisfiable    = rsp_sat_ff;
   assign rsp_chan.variable       = rsp_var_ff;
   assign rsp_chan.chosen_literal = rsp_cho_ff;
   assign rsp_chan.edges_dropped  = rsp_drop_ff;
   assign rsp_chan.last           = rsp_last_ff;

   always_ff @(posedge clock) begin
      if (head_we) begin
         head_mem[src_ff] <= count_ff;
      end
      head_q <= head_mem[head_ra];
   end

   always_ff @(posedge clock) begin
      if (edge_we) begin
         edge_mem[count_ff[EIDX_W-1:0]] <= {dst_ff, hvalid_ff[src_ff] ? head_q : NIL_EDGE};
      end
      edge_q <= edge_mem[edge_ra];
   end

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_mem[stk_wa] <= t_link;
      end
      stk_q <= stk_mem[stk_ra];
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      flag_in      = flag_ff;
      hvalid_in    = hvalid_ff;
      marked_in    = marked_ff;
      attempt_in   = attempt_ff;
      src_in       = src_ff;
      dst_in       = dst_ff;
      lit_in       = lit_ff;
      ent_in       = ent_ff;
      phase_in     = phase_ff;
      v_in         = v_ff;
      nv_in        = nv_ff;
      depth_in     = depth_ff;
      top_in       = top_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_sat_in   = rsp_sat_ff;
      rsp_var_in   = rsp_var_ff;
      rsp_cho_in   = rsp_cho_ff;
      rsp_drop_in  = rsp_drop_ff;
      rsp_last_in  = rsp_last_ff;
      head_we      = 1'b0;
      edge_we      = 1'b0;
      stk_we       = 1'b0;
      head_ra      = ent_ff;

      case (state_ff)
         ST_IDLE: begin
            head_ra = req_chan.src_literal[LIT_W-1:0];
            src_in  = req_chan.src_literal[LIT_W-1:0];
            dst_in  = req_chan.dst_literal[LIT_W-1:0];
            if (req_chan.valid) begin
               case (op_type'(req_chan.op))
                  OP_ADD: begin
                     if ({1'b0, req_chan.src_literal} < 7'(NUM_LITS) &&
                         {1'b0, req_chan.dst_literal} < 7'(NUM_LITS)) begin
                        if (count_ff == NIL_EDGE) begin
                           flag_in = 1'b1;
                        end else begin
                           state_in = ST_ADD;
                        end
                     end
                  end
                  OP_SOLVE: begin
                     marked_in  = '0;
                     attempt_in = '0;
                     v_in       = '0;
                     state_in   = ST_VAR;
                     if (var_count_ff == 6'd0) begin
                        nv_in = CNT_W'(1);
                     end else if ({1'b0, var_count_ff} > 7'(NUM_VARS)) begin
                        nv_in = CNT_W'(NUM_VARS);
                     end else begin
                        nv_in = CNT_W'(var_count_ff);
                     end
                  end
                  OP_CLEAR: begin
                     hvalid_in = '0;
                     count_in  = '0;
                     flag_in   = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_ADD: begin
            edge_we           = 1'b1;
            head_we           = 1'b1;
            hvalid_in[src_ff] = 1'b1;
            count_in          = count_ff + EDGE_W'(1);
            state_in          = ST_IDLE;
         end
         ST_VAR: begin
            if (v_ff == nv_ff) begin
               v_in     = '0;
               state_in = ST_EMIT;
            end else if (marked_ff[v_lit] || marked_ff[v_lit | LIT_W'(1)]) begin
               v_in = v_ff + CNT_W'(1);
            end else begin
               lit_in     = v_lit;
               phase_in   = 1'b0;
               attempt_in = '0;
               state_in   = ST_TRY;
            end
         end
         ST_TRY: begin
            head_ra  = lit_ff;
            depth_in = '0;
            if (marked_ff[lit_comp]) begin
               marked_in  = marked_ff & ~attempt_ff;
               attempt_in = '0;
               if (phase_ff) begin
                  state_in = ST_UNSAT;
               end else begin
                  lit_in   = lit_comp;
                  phase_in = 1'b1;
               end
            end else if (marked_ff[lit_ff]) begin
               v_in     = v_ff + CNT_W'(1);
               state_in = ST_VAR;
            end else begin
               marked_in[lit_ff]  = 1'b1;
               attempt_in[lit_ff] = 1'b1;
               ent_in             = lit_ff;
               state_in           = ST_HEAD;
            end
         end
         ST_HEAD: begin
            top_in   = hvalid_ff[ent_ff] ? head_q : NIL_EDGE;
            depth_in = depth_ff + DEPTH_W'(1);
            state_in = ST_WALK;
         end
         ST_WALK: begin
            if (depth_ff == '0) begin
               v_in     = v_ff + CNT_W'(1);
               state_in = ST_VAR;
            end else if (top_ff == NIL_EDGE) begin
               depth_in = depth_m1;
               state_in = (depth_ff > DEPTH_W'(1)) ? ST_POP : ST_WALK;
            end else begin
               state_in = ST_EDGE;
            end
         end
         ST_POP: begin
            top_in   = stk_q;
            state_in = ST_WALK;
         end
         ST_EDGE: begin
            top_in = t_link;
            head_ra = t_lit;
            if (marked_ff[t_comp]) begin
               // undo this attempt, then retry with the complement, or report unsatisfiable if it was already tried
               marked_in  = marked_ff & ~attempt_ff;
               attempt_in = '0;
               if (phase_ff) begin
                  state_in = ST_UNSAT;
               end else begin
                  lit_in   = lit_comp;
                  phase_in = 1'b1;
                  state_in = ST_TRY;
               end
            end else if (!marked_ff[t_lit]) begin
               marked_in[t_lit]  = 1'b1;
               attempt_in[t_lit] = 1'b1;
               ent_in            = t_lit;
               stk_we            = 1'b1;
               state_in          = ST_HEAD;
            end else begin
               state_in = ST_WALK;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_sat_in   = 1'b1;
               rsp_var_in   = 5'(v_ff[VAR_W-1:0]);
               rsp_cho_in   = !marked_ff[v_lit];
               rsp_drop_in  = flag_ff;
               rsp_last_in  = (v_ff + CNT_W'(1) == nv_ff);
               v_in         = v_ff + CNT_W'(1);
               if (v_ff + CNT_W'(1) == nv_ff) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_UNSAT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_sat_in   = 1'b0;
               rsp_var_in   = '0;
               rsp_cho_in   = 1'b0;
               rsp_drop_in  = flag_ff;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         var_count_ff <= VAR_COUNT_RESET;
         count_ff     <= '0;
         flag_ff      <= 1'b0;
         hvalid_ff    <= '0;
         marked_ff    <= '0;
         attempt_ff   <= '0;
         depth_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         if (csr_wr_en) begin
            var_count_ff <= csr_wr_data;
         end
         count_ff     <= count_in;
         flag_ff      <= flag_in;
         hvalid_ff    <= hvalid_in;
         marked_ff    <= marked_in;
         attempt_ff   <= attempt_in;
         depth_ff     <= depth_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      src_ff      <= src_in;
      dst_ff      <= dst_in;
      lit_ff      <= lit_in;
      ent_ff      <= ent_in;
      phase_ff    <= phase_in;
      v_ff        <= v_in;
      nv_ff       <= nv_in;
      top_ff      <= top_in;
      rsp_sat_ff  <= rsp_sat_in;
      rsp_var_ff  <= rsp_var_in;
      rsp_cho_ff  <= rsp_cho_in;
      rsp_drop_ff <= rsp_drop_in;
      rsp_last_ff <= rsp_last_in;
   end
endmodule
`default_nettype wire

// ----- sv/tsat_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsat_checker
// Port-level checks of the solver's result channel.
// ----------------------------------------------------------------------------
module tsat_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic       rsp_sat,
   input wire logic [4:0] rsp_var,
   input wire logic       rsp_cho,
   input wire logic       rsp_last
);
   a_valid_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_payload_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_var) && $stable(rsp_sat) && $stable(rsp_last))
      else $error("result payload changed while stalled");

   a_unsat_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_sat |-> rsp_last && rsp_var == 5'd0 && !rsp_cho)
      else $error("malformed unsatisfiable result");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");
endmodule

bind two_sat_dfs_solver tsat_checker u_tsat_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_sat   (rsp_chan.satisfiable),
   .rsp_var   (rsp_chan.variable),
   .rsp_cho   (rsp_chan.chosen_literal),
   .rsp_last  (rsp_chan.last)
);
`default_nettype wire
